// ===== sv/grp_pkg.sv =====
// Shared types, constants and helpers for the gray rectangle packetizer.
`timescale 1ns / 1ps
`default_nettype none
package grp_pkg;

  localparam int MAX_PAYLOAD = 1019;
  localparam int DIV_BITS    = 16;
  localparam int DIV_CNT_W   = $clog2(DIV_BITS + 1);
  localparam int RPP_W       = 10;
  localparam int RPP_CAP     = (1 << RPP_W) - 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COMMAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_COMMAND = 3'd5;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
    logic       frame_end;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [7:0] rect_width;
    logic [7:0] rect_height;
    logic [7:0] draw_command;
    logic [7:0] flush_command;
  } cfg_t;

  // one classified pixel, as handed from the front to the back
  typedef struct packed {
    logic       hdr;
    logic [7:0] y_byte;
    logic [7:0] rows;
    logic [9:0] sum;
    logic       pkt_end;
    logic       frame_last;
  } qent_t;

  function automatic logic [7:0] eff_dim(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage
`default_nettype wire

// ===== sv/grp_rpp_div.sv =====
// Bit-serial divider for rows per packet: MAX_PAYLOAD / width, clamped.
`timescale 1ns / 1ps
`default_nettype none
module grp_rpp_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    restart,
  input  logic [7:0]              width,
  output logic                    busy,
  output logic [grp_pkg::RPP_W-1:0] rpp
);
  import grp_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_BITS-1:0]  dvd;
  logic [7:0]           rem;
  logic [DIV_BITS-1:0]  quo;
  logic [8:0]           rem_sh;
  logic                 fits;
  logic [8:0]           rem_next;
  logic [DIV_BITS-1:0]  quo_next;
  logic [RPP_W-1:0]     rpp_next;

  always_comb begin
    rem_sh   = {rem, dvd[DIV_BITS-1]};
    fits     = rem_sh >= {1'b0, width};
    rem_next = fits ? (rem_sh - {1'b0, width}) : rem_sh;
    quo_next = {quo[DIV_BITS-2:0], fits};
    if (quo_next > DIV_BITS'(RPP_CAP)) begin
      rpp_next = RPP_W'(RPP_CAP);
    end else if (quo_next == '0) begin
      rpp_next = RPP_W'(1);
    end else begin
      rpp_next = quo_next[RPP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_BITS);
      dvd  <= DIV_BITS'(MAX_PAYLOAD);
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      dvd <= {dvd[DIV_BITS-2:0], 1'b0};
      rem <= rem_next[7:0];
      quo <= quo_next;
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy && cnt == DIV_CNT_W'(1) && !restart) begin
      rpp <= rpp_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/grp_front.sv =====
// Front end: raster counters, packet classification and header fields per pixel.
`timescale 1ns / 1ps
`default_nettype none
module grp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  grp_pkg::pixel_t           pixel,
  input  grp_pkg::cfg_t             cfg,
  input  logic [grp_pkg::RPP_W-1:0] rpp_new,
  output grp_pkg::qent_t            entry
);
  import grp_pkg::*;

  logic [7:0]       column_count;
  logic [7:0]       row_count;
  logic [RPP_W-1:0] row_in_packet;
  logic [RPP_W-1:0] rows_per_packet;

  logic [7:0]       w;
  logic [7:0]       h;
  logic             frame_start;
  logic             line_start;
  logic [RPP_W-1:0] rpp_use;
  logic [7:0]       left;
  logic             row_end;
  logic             frame_last;
  logic             pkt_end;

  always_comb begin
    w           = eff_dim(cfg.rect_width);
    h           = eff_dim(cfg.rect_height);
    frame_start = (column_count == 8'd0) && (row_count == 8'd0) && (row_in_packet == '0);
    line_start  = (column_count == 8'd0) && (row_in_packet == '0);
    rpp_use     = frame_start ? rpp_new : rows_per_packet;
    left        = (h > row_count) ? (h - row_count) : 8'd1;
    row_end     = ({1'b0, column_count} + 9'd1) >= {1'b0, w};
    frame_last  = row_end && (({1'b0, row_count} + 9'd1) >= {1'b0, h});
    pkt_end     = row_end &&
                  ((({1'b0, row_in_packet} + (RPP_W+1)'(1)) >= {1'b0, rpp_use}) || frame_last);

    entry.hdr        = line_start;
    entry.y_byte     = cfg.origin_y + row_count;
    entry.rows       = ({{(RPP_W-8){1'b0}}, left} < rpp_use) ? left : rpp_use[7:0];
    entry.sum        = {2'b00, pixel.red} + {2'b00, pixel.green} + {2'b00, pixel.blue};
    entry.pkt_end    = pkt_end;
    entry.frame_last = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      row_in_packet   <= '0;
      rows_per_packet <= RPP_W'(1);
    end else if (accept) begin
      rows_per_packet <= rpp_use;
      if (row_end) begin
        column_count <= '0;
        if (frame_last) begin
          row_count     <= '0;
          row_in_packet <= '0;
        end else begin
          row_count     <= row_count + 8'd1;
          row_in_packet <= pkt_end ? '0 : (row_in_packet + RPP_W'(1));
        end
      end else begin
        column_count <= column_count + 8'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/grp_fifo.sv =====
// Short queue of classified pixels between front and back.
`timescale 1ns / 1ps
`default_nettype none
module grp_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  grp_pkg::qent_t wr,
  input  logic           pop,
  output grp_pkg::qent_t head,
  output logic           full,
  output logic           empty
);
  import grp_pkg::*;

  qent_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/grp_back.sv =====
// Back end: walks each queued pixel through header, gray and flush bytes.
`timescale 1ns / 1ps
`default_nettype none
module grp_back (
  input  logic             clk,
  input  logic             rst,
  input  grp_pkg::qent_t   head,
  input  logic             head_valid,
  output logic             pop,
  input  grp_pkg::cfg_t    cfg,
  input  logic             result_stall,
  output logic             result_valid,
  output grp_pkg::result_t result
);
  import grp_pkg::*;

  localparam logic [2:0] PH_DRAW  = 3'd0;
  localparam logic [2:0] PH_X     = 3'd1;
  localparam logic [2:0] PH_Y     = 3'd2;
  localparam logic [2:0] PH_W     = 3'd3;
  localparam logic [2:0] PH_ROWS  = 3'd4;
  localparam logic [2:0] PH_GRAY  = 3'd5;
  localparam logic [2:0] PH_FLUSH = 3'd6;

  logic [2:0]  phase;
  logic [2:0]  cur;
  logic        load;
  logic        last;
  logic [20:0] product;
  logic [7:0]  gray;
  result_t     res_next;

  always_comb begin
    cur     = (phase == PH_DRAW && !head.hdr) ? PH_GRAY : phase;
    load    = head_valid && (!result_valid || !result_stall);
    last    = (cur == PH_GRAY && !head.frame_last) || (cur == PH_FLUSH);
    pop     = load && last;
    // x / 3 == (x * 683) >> 11 for x below 2048
    product = {11'd0, head.sum} * 21'd683;
    gray    = product[18:11];

    res_next = '0;
    unique case (cur)
      PH_DRAW:  res_next.data_byte = cfg.draw_command;
      PH_X:     res_next.data_byte = cfg.origin_x;
      PH_Y:     res_next.data_byte = head.y_byte;
      PH_W:     res_next.data_byte = eff_dim(cfg.rect_width);
      PH_ROWS:  res_next.data_byte = head.rows;
      PH_GRAY: begin
        res_next.data_byte  = gray;
        res_next.packet_end = head.pkt_end;
        res_next.run_last   = !head.frame_last;
      end
      PH_FLUSH: begin
        res_next.data_byte  = cfg.flush_command;
        res_next.packet_end = 1'b1;
        res_next.frame_end  = 1'b1;
        res_next.run_last   = 1'b1;
      end
      default:  res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DRAW;
      result_valid <= 1'b0;
    end else if (load) begin
      phase        <= last ? PH_DRAW : (cur + 3'd1);
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/gray_rect_packetizer.sv =====
// Gray rectangle packetizer: pixels in, packet byte stream out.
// A taken pixel is written into the queue, then its result bytes are registered in the back end.
// Throughput: one result byte per cycle while result_stall is low; a pixel that opens
// a packet yields six bytes, others one, and closing the frame adds the flush byte.
// After reset and after each width write, pixels stall while the divider computes rows per packet.
// Reset is synchronous: counters and queue clear, registers take their reset values.
`timescale 1ns / 1ps
`default_nettype none
module gray_rect_packetizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_stall,
  input  grp_pkg::pixel_t               pixel,
  output logic                          result_valid,
  input  logic                          result_stall,
  output grp_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [grp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import grp_pkg::*;

  cfg_t             cfg;
  logic             cfg_write;
  logic             div_busy;
  logic [RPP_W-1:0] rpp_new;
  logic             accept;
  qent_t            entry;
  qent_t            head;
  logic             fifo_full;
  logic             fifo_empty;
  logic             pop;

  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign pixel_stall = div_busy || fifo_full;
  assign accept      = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= 8'd0;
      cfg.origin_y      <= 8'd0;
      cfg.rect_width    <= 8'd1;
      cfg.rect_height   <= 8'd1;
      cfg.draw_command  <= 8'd0;
      cfg.flush_command <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:      cfg.origin_x      <= cfg_data;
        CFG_ORIGIN_Y:      cfg.origin_y      <= cfg_data;
        CFG_RECT_WIDTH:    cfg.rect_width    <= cfg_data;
        CFG_RECT_HEIGHT:   cfg.rect_height   <= cfg_data;
        CFG_DRAW_COMMAND:  cfg.draw_command  <= cfg_data;
        CFG_FLUSH_COMMAND: cfg.flush_command <= cfg_data;
        default: ;
      endcase
    end
  end

  grp_rpp_div u_div (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write && cfg_index == CFG_RECT_WIDTH),
    .width   (eff_dim(cfg.rect_width)),
    .busy    (div_busy),
    .rpp     (rpp_new)
  );

  grp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .pixel   (pixel),
    .cfg     (cfg),
    .rpp_new (rpp_new),
    .entry   (entry)
  );

  grp_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (accept),
    .wr    (entry),
    .pop   (pop),
    .head  (head),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  grp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (!fifo_empty),
    .pop          (pop),
    .cfg          (cfg),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  a_div_blocks_pixels: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> pixel_stall)
    else $error("pixel request taken while rows per packet is being computed");

  a_rpp_nonzero: assert property (@(posedge clk) disable iff (rst)
    !div_busy |-> (rpp_new != '0))
    else $error("rows per packet is zero");

  a_frame_end_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_end) |-> (result.packet_end && result.run_last))
    else $error("frame end byte does not close packet and request");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_empty)
    else $error("queue popped while empty");

endmodule
`default_nettype wire
